/* rtl/assert_macros.svh */
// Assertion helpers for the RTL; refraction_vector.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define RV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define RV_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/refv_pkg.sv */
package refv_pkg;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned N_W      = 21;
  localparam int unsigned THR_W    = 17;
  localparam int unsigned VEC_W    = COORD_W + 1;
  localparam int unsigned MAG_W    = 30;
  localparam int unsigned SUM_W    = 2 * MAG_W + 2;
  localparam int unsigned LEN_SQ_W = 64;
  localparam int unsigned LEN_W    = LEN_SQ_W / 2;
  localparam int unsigned UNIT_W   = 32;
  localparam int unsigned DIV_STG  = 31;
  localparam int unsigned UNIT_LAT = 5 + LEN_W + DIV_STG + 1;
  localparam int unsigned RAD_W    = 62;
  localparam int unsigned ROOT_W   = RAD_W / 2;

  typedef logic signed [VEC_W-1:0]  vec_t;
  typedef logic signed [UNIT_W-1:0] unit_t;
  typedef logic [MAG_W-1:0]         mag_t;

endpackage

/* rtl/refv_delay.sv */
module refv_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned D = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] line_q [D];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      line_q[0] <= d_i;
      for (int i = 1; i < D; i++) begin
        line_q[i] <= line_q[i-1];
      end
    end
  end

  assign q_o = line_q[D-1];

endmodule

/* rtl/refv_isqrt.sv */
// Floor square root, one result bit per stage.
module refv_isqrt #(
  parameter int unsigned W = 64
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [W-1:0]   rad_i,
  output logic [W/2-1:0] root_o
);

  localparam int unsigned N  = W / 2;
  localparam int unsigned RW = N + 3;

  logic [W-1:0]  x_q    [N];
  logic [RW-1:0] rem_q  [N];
  logic [N-1:0]  root_q [N];

  for (genvar g = 0; g < N; g++) begin : g_stg
    logic [W-1:0]  x_in;
    logic [RW-1:0] rem_in;
    logic [N-1:0]  root_in;
    logic [RW-1:0] cur;
    logic [RW-1:0] trial;

    if (g == 0) begin : g_first
      assign x_in    = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign x_in    = x_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
    end

    // bring down the next two radicand bits
    assign cur   = {rem_in[RW-3:0], x_in[W-1:W-2]};
    assign trial = RW'({root_in, 2'b01});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[g] <= {x_in[W-3:0], 2'b00};
        if (cur >= trial) begin
          rem_q[g]  <= cur - trial;
          root_q[g] <= {root_in[N-2:0], 1'b1};
        end else begin
          rem_q[g]  <= cur;
          root_q[g] <= {root_in[N-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule

/* rtl/refv_div.sv */
// Restoring divider: floor(mag * 2^30 / len), one quotient bit per stage.
module refv_div
  import refv_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  mag_t               mag_i,
  input  logic               sgn_i,
  input  logic [LEN_W-1:0]   len_i,
  output logic [DIV_STG-1:0] quo_o,
  output logic               sgn_o
);

  logic [LEN_W-1:0]   rem_q [DIV_STG];
  logic [LEN_W-1:0]   len_q [DIV_STG];
  logic [DIV_STG-1:0] quo_q [DIV_STG];
  logic               sgn_q [DIV_STG];

  for (genvar g = 0; g < DIV_STG; g++) begin : g_stg
    logic [LEN_W-1:0]   cur;
    logic [LEN_W-1:0]   len_in;
    logic [DIV_STG-1:0] quo_in;
    logic               sgn_in;
    logic               ge;

    if (g == 0) begin : g_first
      // magnitude never exceeds the length, so the top quotient bit starts here
      assign cur    = LEN_W'(mag_i);
      assign len_in = len_i;
      assign quo_in = '0;
      assign sgn_in = sgn_i;
    end else begin : g_next
      assign cur    = {rem_q[g-1][LEN_W-2:0], 1'b0};
      assign len_in = len_q[g-1];
      assign quo_in = quo_q[g-1];
      assign sgn_in = sgn_q[g-1];
    end

    assign ge = (cur >= len_in);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= ge ? cur - len_in : cur;
        len_q[g] <= len_in;
        quo_q[g] <= {quo_in[DIV_STG-2:0], ge};
        sgn_q[g] <= sgn_in;
      end
    end
  end

  assign quo_o = quo_q[DIV_STG-1];
  assign sgn_o = sgn_q[DIV_STG-1];

endmodule

/* rtl/refv_unit.sv */
// Scales a 3-vector to unit length in Q2.30.
module refv_unit
  import refv_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  vec_t  [2:0] vec_i,
  output unit_t [2:0] unit_o,
  output logic        zero_o
);

  logic [VEC_W-1:0] mag_d [3];
  logic [VEC_W-1:0] max_d;
  logic [VEC_W-1:0] mag1_q [3];
  logic [VEC_W-1:0] max1_q;
  logic [2:0]       sgn1_q;

  logic [5:0]       lead_d;
  logic             right_d;
  logic [4:0]       sh_d;
  logic [VEC_W-1:0] mag2_q [3];
  logic [2:0]       sgn2_q;
  logic             right2_q;
  logic [4:0]       sh2_q;
  logic             zero2_q;

  mag_t [2:0]         mag3_q;
  logic [2:0]         sgn3_q;
  logic               zero3_q;
  logic [2*MAG_W-1:0] sq4_q [3];
  mag_t [2:0]         mag4_q;
  logic [2:0]         sgn4_q;
  logic               zero4_q;
  logic [SUM_W-1:0]   sum5_q;
  mag_t [2:0]         mag5_q;
  logic [2:0]         sgn5_q;
  logic               zero5_q;

  logic [LEN_W-1:0]   len;
  mag_t [2:0]         mag_l;
  logic [2:0]         sgn_l;
  logic               zero_l;
  logic [DIV_STG-1:0] quo [3];
  logic [2:0]         sgn_q_w;

  unit_t [2:0] unit_q;
  logic        zero_q;

  always_comb begin
    max_d = '0;
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = vec_i[i][VEC_W-1] ? (~vec_i[i] + VEC_W'(1)) : vec_i[i];
      if (mag_d[i] > max_d) max_d = mag_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        mag1_q[i] <= mag_d[i];
        sgn1_q[i] <= vec_i[i][VEC_W-1];
      end
      max1_q <= max_d;
    end
  end

  // place the largest magnitude in [2^29, 2^30)
  always_comb begin
    lead_d = '0;
    for (int i = 0; i < VEC_W; i++) begin
      if (max1_q[i]) lead_d = 6'(i);
    end
    right_d = lead_d > 6'(MAG_W - 1);
    sh_d    = right_d ? 5'(lead_d - 6'(MAG_W - 1)) : 5'(6'(MAG_W - 1) - lead_d);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag2_q   <= mag1_q;
      sgn2_q   <= sgn1_q;
      right2_q <= right_d;
      sh2_q    <= sh_d;
      zero2_q  <= (max1_q == '0);

      for (int i = 0; i < 3; i++) begin
        mag3_q[i] <= right2_q ? MAG_W'(mag2_q[i] >> sh2_q) : MAG_W'(mag2_q[i] << sh2_q);
      end
      sgn3_q  <= sgn2_q;
      zero3_q <= zero2_q;

      for (int i = 0; i < 3; i++) begin
        sq4_q[i] <= mag3_q[i] * mag3_q[i];
      end
      mag4_q  <= mag3_q;
      sgn4_q  <= sgn3_q;
      zero4_q <= zero3_q;

      sum5_q  <= SUM_W'(sq4_q[0]) + SUM_W'(sq4_q[1]) + SUM_W'(sq4_q[2]);
      mag5_q  <= mag4_q;
      sgn5_q  <= sgn4_q;
      zero5_q <= zero4_q;
    end
  end

  refv_isqrt #(
    .W (LEN_SQ_W)
  ) u_len (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .rad_i  ({{(LEN_SQ_W - SUM_W){1'b0}}, sum5_q}),
    .root_o (len)
  );

  refv_delay #(
    .W (3 * MAG_W + 3),
    .D (LEN_W)
  ) u_mag_dly (
    .clk_i (clk_i),
    .en_i  (en_i),
    .d_i   ({mag5_q, sgn5_q}),
    .q_o   ({mag_l, sgn_l})
  );

  refv_delay #(
    .W (1),
    .D (LEN_W + DIV_STG)
  ) u_zero_dly (
    .clk_i (clk_i),
    .en_i  (en_i),
    .d_i   (zero5_q),
    .q_o   (zero_l)
  );

  for (genvar g = 0; g < 3; g++) begin : g_lane
    refv_div u_div (
      .clk_i (clk_i),
      .en_i  (en_i),
      .mag_i (mag_l[g]),
      .sgn_i (sgn_l[g]),
      .len_i (len),
      .quo_o (quo[g]),
      .sgn_o (sgn_q_w[g])
    );

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        unit_q[g] <= sgn_q_w[g] ? -unit_t'({1'b0, quo[g]}) : unit_t'({1'b0, quo[g]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) zero_q <= zero_l;
  end

  assign unit_o = unit_q;
  assign zero_o = zero_q;

endmodule

/* rtl/refraction_vector.sv */
// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid_i / in_stall_o    | origin, hit, normal, index_ratio
// out     | output    | out_valid_o / out_stall_i  | dir_x/y/z, total_internal, degenerate
// cfg     | input     | cfg_valid_i / cfg_ready_o  | tir_threshold
//
// Takes one ray per cycle while in_stall_o is low; pipeline depth comes mostly from the bit-serial
// square root and division stages (direction and normal unit-length passes in parallel, then the radicand root).
// Reset clears valid bits, output and skid flags; tir_threshold resets to 1.
// A stalled output parks one beat in a skid register; in_stall_o is that flag, registered.
// Every stage advances on one enable, so a stall holds all beats in place.
`include "assert_macros.svh"

module refraction_vector
  import refv_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [COORD_W-1:0] origin_x_i,
  input  logic signed [COORD_W-1:0] origin_y_i,
  input  logic signed [COORD_W-1:0] origin_z_i,
  input  logic signed [COORD_W-1:0] hit_x_i,
  input  logic signed [COORD_W-1:0] hit_y_i,
  input  logic signed [COORD_W-1:0] hit_z_i,
  input  logic signed [COORD_W-1:0] normal_x_i,
  input  logic signed [COORD_W-1:0] normal_y_i,
  input  logic signed [COORD_W-1:0] normal_z_i,
  input  logic [N_W-1:0]           index_ratio_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [COORD_W-1:0] dir_x_o,
  output logic signed [COORD_W-1:0] dir_y_o,
  output logic signed [COORD_W-1:0] dir_z_o,
  output logic                     total_internal_o,
  output logic                     degenerate_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [THR_W-1:0]         tir_threshold_i
);

  localparam int unsigned LAT = 1 + UNIT_LAT + 6 + ROOT_W + 3;

  typedef struct packed {
    unit_t [2:0]    u;
    unit_t [2:0]    nu;
    logic [N_W-1:0] n;
    logic           deg;
  } car_t;

  typedef struct packed {
    car_t               car;
    logic signed [53:0] ns;
    logic               tir;
  } bun_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] dir;
    logic                    tir;
    logic                    deg;
  } res_t;

  logic             en;
  logic [LAT-1:0]   vld_q;
  logic [THR_W-1:0] thr_q;

  vec_t [2:0]     dv0_q;
  vec_t [2:0]     nv0_q;
  logic [N_W-1:0] n0_q;

  unit_t [2:0]    ud;
  unit_t [2:0]    un;
  logic           zd;
  logic           zn;
  logic [N_W-1:0] n_u;

  logic signed [63:0] p1_q [3];
  car_t               car1_q;
  logic signed [63:0] dot_d;
  logic signed [63:0] dsh_d;
  logic signed [31:0] s_d;
  logic signed [31:0] s2_q;
  car_t               car2_q;
  logic signed [63:0] ss3_q;
  logic signed [53:0] ns3_q;
  logic [41:0]        nsq3_q;
  car_t               car3_q;
  logic [33:0]        qa_d;
  logic signed [31:0] qm_d;
  logic signed [31:0] qm4_q;
  logic [25:0]        n24_q;
  logic signed [53:0] ns4_q;
  car_t               car4_q;
  logic signed [58:0] prod5_q;
  logic signed [53:0] ns5_q;
  car_t               car5_q;
  logic signed [43:0] t_d;
  logic               gt_d;
  logic [RAD_W-1:0]   rad6_q;
  bun_t               bun6_q;
  bun_t               bun_r;
  logic [ROOT_W-1:0]  root;

  logic signed [38:0] cdiff_d;
  logic signed [24:0] c7_q;
  car_t               car7_q;
  logic               tir7_q;
  logic signed [53:0] a8_q [3];
  logic signed [56:0] b8_q [3];
  logic               tir8_q;
  logic               deg8_q;
  logic signed [57:0] df_d [3];
  res_t               res_d;
  res_t               res9_q;

  logic pv;
  logic take;
  logic out_v_q;
  logic skid_v_q;
  res_t out_q;
  res_t skid_q;

  assign en          = !skid_v_q;
  assign in_stall_o  = skid_v_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_W'(1);
    end else if (cfg_valid_i) begin
      thr_q <= tir_threshold_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv0_q[0] <= $signed({hit_x_i[COORD_W-1], hit_x_i}) - $signed({origin_x_i[COORD_W-1], origin_x_i});
      dv0_q[1] <= $signed({hit_y_i[COORD_W-1], hit_y_i}) - $signed({origin_y_i[COORD_W-1], origin_y_i});
      dv0_q[2] <= $signed({hit_z_i[COORD_W-1], hit_z_i}) - $signed({origin_z_i[COORD_W-1], origin_z_i});
      nv0_q[0] <= {normal_x_i[COORD_W-1], normal_x_i};
      nv0_q[1] <= {normal_y_i[COORD_W-1], normal_y_i};
      nv0_q[2] <= {normal_z_i[COORD_W-1], normal_z_i};
      n0_q     <= index_ratio_i;
    end
  end

  refv_unit u_unit_dir (
    .clk_i  (clk_i),
    .en_i   (en),
    .vec_i  (dv0_q),
    .unit_o (ud),
    .zero_o (zd)
  );

  refv_unit u_unit_nrm (
    .clk_i  (clk_i),
    .en_i   (en),
    .vec_i  (nv0_q),
    .unit_o (un),
    .zero_o (zn)
  );

  refv_delay #(
    .W (N_W),
    .D (UNIT_LAT)
  ) u_n_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (n0_q),
    .q_o   (n_u)
  );

  // dot product, then clamp s to [-1, 1]
  always_comb begin
    dot_d = p1_q[0] + p1_q[1] + p1_q[2];
    dsh_d = dot_d >>> 30;
    if (dsh_d > 64'sh4000_0000) begin
      s_d = 32'sh4000_0000;
    end else if (dsh_d < -64'sh4000_0000) begin
      s_d = -32'sh4000_0000;
    end else begin
      s_d = dsh_d[31:0];
    end
  end

  always_comb begin
    qa_d = ss3_q[63:30];
    qm_d = (qa_d >= 34'h4000_0000) ? '0 : $signed({2'b00, qa_d[29:0]}) - 32'sh4000_0000;
  end

  always_comb begin
    t_d  = 44'sh000_4000_0000 + $signed(prod5_q[58:16]);
    gt_d = t_d > $signed({13'b0, thr_q, 14'b0});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1_q[i] <= $signed(ud[i]) * $signed(un[i]);
      end
      car1_q.u   <= ud;
      car1_q.nu  <= un;
      car1_q.n   <= n_u;
      car1_q.deg <= zd | zn;

      s2_q   <= s_d;
      car2_q <= car1_q;

      ss3_q  <= s2_q * s2_q;
      ns3_q  <= $signed({1'b0, car2_q.n}) * s2_q;
      nsq3_q <= car2_q.n * car2_q.n;
      car3_q <= car2_q;

      qm4_q  <= qm_d;
      n24_q  <= nsq3_q[41:16];
      ns4_q  <= ns3_q;
      car4_q <= car3_q;

      prod5_q <= $signed({1'b0, n24_q}) * qm4_q;
      ns5_q   <= ns4_q;
      car5_q  <= car4_q;

      // radicand at or below the threshold: no root, flag total internal reflection
      rad6_q     <= gt_d ? {1'b0, t_d[30:0], 30'b0} : '0;
      bun6_q.car <= car5_q;
      bun6_q.ns  <= ns5_q;
      bun6_q.tir <= !gt_d;
    end
  end

  refv_isqrt #(
    .W (RAD_W)
  ) u_root (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad6_q),
    .root_o (root)
  );

  refv_delay #(
    .W ($bits(bun_t)),
    .D (ROOT_W)
  ) u_bun_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (bun6_q),
    .q_o   (bun_r)
  );

  assign cdiff_d = $signed({bun_r.ns[53], bun_r.ns[53:16]}) - $signed({8'b0, root});

  // the result stays far inside 32 bits, so saturation reduces to sign extension
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      df_d[i]       = 58'(a8_q[i]) - 58'(b8_q[i]);
      res_d.dir[i]  = deg8_q ? '0 : {{4{df_d[i][57]}}, df_d[i][57:30]};
    end
    res_d.tir = tir8_q & !deg8_q;
    res_d.deg = deg8_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c7_q   <= cdiff_d[38:14];
      car7_q <= bun_r.car;
      tir7_q <= bun_r.tir;

      for (int i = 0; i < 3; i++) begin
        a8_q[i] <= $signed({1'b0, car7_q.n}) * $signed(car7_q.u[i]);
        b8_q[i] <= c7_q * $signed(car7_q.nu[i]);
      end
      tir8_q <= tir7_q;
      deg8_q <= car7_q.deg;

      res9_q <= res_d;
    end
  end

  assign pv   = vld_q[LAT-1];
  assign take = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (take) begin
      out_v_q <= pv;
    end else if (pv) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) out_q <= skid_q;
    end else if (take) begin
      out_q <= res9_q;
    end else begin
      skid_q <= res9_q;
    end
  end

  assign out_valid_o      = out_v_q;
  assign dir_x_o          = $signed(out_q.dir[0]);
  assign dir_y_o          = $signed(out_q.dir[1]);
  assign dir_z_o          = $signed(out_q.dir[2]);
  assign total_internal_o = out_q.tir;
  assign degenerate_o     = out_q.deg;

  `RV_ASSERT_ALL(a_skid_needs_out, skid_v_q |-> out_v_q, "skid holds a beat while output is empty")
  `RV_ASSERT(a_skid_catch, (out_v_q && out_stall_i && pv && !skid_v_q) |=> skid_v_q, "stalled beat not parked in skid")
  `RV_ASSERT(a_deg_clean, (out_v_q && degenerate_o) |-> (dir_x_o == 0 && dir_y_o == 0 && dir_z_o == 0 && !total_internal_o), "degenerate beat carries a direction")

endmodule

/* tb/tb_refraction_vector.sv */
`timescale 1ns / 100ps

module tb_refraction_vector
  import refv_pkg::*;
();

  localparam int unsigned PIPE_LAT = 110;
  localparam int unsigned DOG_LIMIT = 2000;

  typedef struct packed {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic               tir;
    logic               degen;
  } dir_res_t;

  typedef struct {
    logic signed [31:0] org[3];
    logic signed [31:0] hit[3];
    logic signed [31:0] nrm[3];
    logic [N_W-1:0]     ratio;
  } ray_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  logic signed [31:0] hit_x_i = '0, hit_y_i = '0, hit_z_i = '0;
  logic signed [31:0] normal_x_i = '0, normal_y_i = '0, normal_z_i = '0;
  logic [N_W-1:0] index_ratio_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] dir_x_o, dir_y_o, dir_z_o;
  logic total_internal_o, degenerate_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [THR_W-1:0] tir_threshold_i = '0;

  refraction_vector dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [THR_W-1:0] threshold_q = 1;
  dir_res_t dir_expected_q[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  bit idle_en = 1'b1;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
    error_count++;
  endtask

  function automatic logic signed [63:0] floor_shr(input logic signed [63:0] x, input int k);
    return x >>> k;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Scale to a Q2.30 unit vector; zero vector returns 0.
  function automatic bit to_unit(input logic signed [63:0] v[3],
                                 output logic signed [63:0] u[3]);
    logic [63:0] mag[3], m, sum, len, q;
    m = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i] < 0 ? -v[i] : v[i];
      if (mag[i] > m) m = mag[i];
    end
    for (int i = 0; i < 3; i++) u[i] = 0;
    if (m == 0) return 1'b0;
    while (m >= (64'd1 << 30)) begin
      m >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] << 30) / len;
      u[i] = v[i] < 0 ? -$signed(q) : $signed(q);
    end
    return 1'b1;
  endfunction

  function automatic dir_res_t refract_ray(input ray_t ray);
    logic signed [63:0] d[3], nv[3], u[3], nu[3];
    logic signed [63:0] one, n, dot, s, q, n2, t, root, c, r;
    bit okd, okn;
    dir_res_t res;
    one = 64'sd1 <<< 30;
    for (int i = 0; i < 3; i++) begin
      d[i] = 64'(ray.hit[i]) - 64'(ray.org[i]);
      nv[i] = 64'(ray.nrm[i]);
    end
    n = $signed({43'd0, ray.ratio});
    okd = to_unit(d, u);
    okn = to_unit(nv, nu);
    res = '0;
    if (!okd || !okn) begin
      res.degen = 1'b1;
      return res;
    end
    dot = u[0] * nu[0] + u[1] * nu[1] + u[2] * nu[2];
    s = floor_shr(dot, 30);
    if (s > one) s = one;
    if (s < -one) s = -one;
    q = floor_shr(s * s, 30);
    if (q > one) q = one;
    n2 = (n * n) >>> 16;
    t = one + floor_shr(n2 * (q - one), 16);
    if (t > $signed({33'd0, threshold_q, 14'd0})) begin
      root = $signed(int_sqrt(t << 30));
    end else begin
      root = 0;
      res.tir = 1'b1;
    end
    c = floor_shr(floor_shr(n * s, 16) - root, 14);
    for (int i = 0; i < 3; i++) begin
      r = floor_shr(n * u[i] - c * nu[i], 30);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      case (i)
        0: res.dx = r[31:0];
        1: res.dy = r[31:0];
        default: res.dz = r[31:0];
      endcase
    end
    return res;
  endfunction

  // Output stall in random bursts; stalls stop once idle_en is cleared.
  always @(posedge clk_i) begin
    if (!idle_en) begin
      stall_left  <= 0;
      out_stall_i <= 1'b0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left  <= 0;
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(1, 5);
      out_stall_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    dir_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (dir_expected_q.size() == 0) begin
        report_mismatch("unexpected beat", dir_x_o, '0);
      end else begin
        want = dir_expected_q.pop_front();
        if (dir_x_o !== want.dx) report_mismatch("dir_x", dir_x_o, want.dx);
        if (dir_y_o !== want.dy) report_mismatch("dir_y", dir_y_o, want.dy);
        if (dir_z_o !== want.dz) report_mismatch("dir_z", dir_z_o, want.dz);
        if (total_internal_o !== want.tir)
          report_mismatch("total_internal", 32'(total_internal_o), 32'(want.tir));
        if (degenerate_o !== want.degen)
          report_mismatch("degenerate", 32'(degenerate_o), 32'(want.degen));
      end
    end
  end

  // Watchdog: count cycles with no accepted beat on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= DOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_ray(input ray_t ray);
    int gap;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    origin_x_i <= ray.org[0];
    origin_y_i <= ray.org[1];
    origin_z_i <= ray.org[2];
    hit_x_i <= ray.hit[0];
    hit_y_i <= ray.hit[1];
    hit_z_i <= ray.hit[2];
    normal_x_i <= ray.nrm[0];
    normal_y_i <= ray.nrm[1];
    normal_z_i <= ray.nrm[2];
    index_ratio_i <= ray.ratio;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    dir_expected_q.push_back(refract_ray(ray));
  endtask

  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (dir_expected_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 10) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    cfg_valid_i <= 1'b1;
    tir_threshold_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    threshold_q = value;
  endtask

  function automatic logic signed [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      2: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic ray_t rand_ray();
    ray_t ray;
    int mode;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) begin
      ray.org[i] = rand_coord(mode);
      ray.hit[i] = rand_coord($urandom_range(0, 3));
      ray.nrm[i] = rand_coord($urandom_range(0, 3));
    end
    case ($urandom_range(0, 5))
      0: ray.ratio = N_W'($urandom());
      1: ray.ratio = N_W'($urandom_range(0, 21'h10_0000));
      default: ray.ratio = N_W'($urandom_range(21'h0_8000, 21'h2_0000));
    endcase
    return ray;
  endfunction

  task automatic test_directed();
    ray_t ray;
    ray = '{org: '{0, 0, 0}, hit: '{0, 0, 32'sh0001_0000},
            nrm: '{0, 0, 32'sh0001_0000}, ratio: 21'h1_0000};
    send_ray(ray);
    ray.hit = '{32'sh0001_0000, 0, 32'sh0001_0000};
    send_ray(ray);
    ray.ratio = 21'h1_8000;
    send_ray(ray);
    ray.ratio = 21'h0;
    send_ray(ray);
    ray.ratio = 21'h1f_ffff;
    send_ray(ray);
    ray.ratio = 21'h10_0000;
    send_ray(ray);
    // Zero incident direction, then zero normal.
    ray.hit = ray.org;
    send_ray(ray);
    ray.hit = '{5, -7, 9};
    ray.nrm = '{0, 0, 0};
    send_ray(ray);
    ray = '{org: '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000},
            hit: '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff},
            nrm: '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000}, ratio: 21'h1_0000};
    send_ray(ray);
    ray.org = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff};
    ray.hit = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
    ray.nrm = '{1, -1, 1};
    ray.ratio = 21'h1f_ffff;
    send_ray(ray);
    ray = '{org: '{0, 0, 0}, hit: '{1, 0, 0}, nrm: '{-1, 0, 0}, ratio: 21'h0_4000};
    send_ray(ray);
    ray.hit = '{-32'sh1234_5678, 32'sh0fed_cba9, 32'sh3};
    ray.nrm = '{32'sh4000_0000, -32'sh4000_0000, 32'sh1};
    ray.ratio = 21'h2_0000;
    send_ray(ray);
  endtask

  task automatic test_threshold_sweep();
    logic [THR_W-1:0] values[4];
    values = '{17'd0, 17'h1_0000, 17'h1_ffff, 17'h0_8000};
    foreach (values[k]) begin
      drain_pipe();
      write_threshold(values[k]);
      repeat (30) send_ray(rand_ray());
    end
  endtask

  task automatic test_random_stream();
    drain_pipe();
    write_threshold(THR_W'($urandom_range(0, 17'h1_0000)));
    repeat (330) send_ray(rand_ray());
    idle_en = 1'b0;
    repeat (100) send_ray(rand_ray());
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_threshold_sweep();
    test_random_stream();
    drain_pipe();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* refraction_vector.f */
+incdir+rtl
rtl/refv_pkg.sv
rtl/refv_delay.sv
rtl/refv_isqrt.sv
rtl/refv_div.sv
rtl/refv_unit.sv
rtl/refraction_vector.sv
tb/tb_refraction_vector.sv
